>>> sv/assert_macros.svh
// assertion macros used by the pixel core rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// same-cycle implication checked outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/idp_pkg.sv
// constants, types and register codes of the inclined disk profile pixel core
// no dependencies
package idp_pkg;

  localparam int DATA_W    = 32;
  localparam int TRIG_W    = 18;
  localparam int RECIP_W   = 24;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE    = 3'd0,
    REG_INV_SCALE    = 3'd1,
    REG_SIN_PA       = 3'd2,
    REG_COS_PA       = 3'd3,
    REG_INV_COS_INC  = 3'd4,
    REG_GAIN         = 3'd5,
    REG_PROFILE_MODE = 3'd6
  } cfg_reg_t;

  // square root unit
  localparam int SQ_RAD_W    = 48;
  localparam int SQ_ROOT_W   = 24;
  localparam int SQRT_STEPS  = 3;
  localparam int SQRT_STAGES = SQ_ROOT_W / SQRT_STEPS;

  // exponential unit
  localparam int EXP_T_W       = 20;
  localparam int EXP_TERMS     = 12;
  localparam int EXP_SQUARINGS = 4;
  localparam int EXP_LAT       = 2 * EXP_TERMS + EXP_SQUARINGS + 1;
  localparam int E_W           = 17;
  localparam int EXP_ZERO_T    = 12 * 65536;

  localparam logic [31:0] Q31_ONE    = 32'h8000_0000;
  localparam logic [23:0] RADIUS_CAP = 24'h80_0000;

  typedef struct packed {
    logic               zero;
    logic [EXP_T_W-1:0] t;
  } exp_arg_t;

endpackage

>>> sv/idp_isqrt.sv
// pipelined integer square root, a few result bits per stage
// depends on idp_pkg
module idp_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [idp_pkg::SQ_RAD_W-1:0]  rad,
  output logic [idp_pkg::SQ_ROOT_W-1:0] root
);
  import idp_pkg::*;

  localparam int REM_W  = SQ_ROOT_W + 2;
  localparam int WORK_W = REM_W + 2;

  logic [SQ_RAD_W-1:0]  rad_q  [SQRT_STAGES];
  logic [REM_W-1:0]     rem_q  [SQRT_STAGES];
  logic [SQ_ROOT_W-1:0] root_q [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [SQ_RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]     rem_in;
    logic [REM_W-1:0]     rem_out;
    logic [SQ_ROOT_W-1:0] root_in;
    logic [SQ_ROOT_W-1:0] root_out;

    if (g == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    always_comb begin
      logic [WORK_W-1:0] work;
      logic [WORK_W-1:0] trial;
      int                pos;
      rem_out  = rem_in;
      root_out = root_in;
      work     = '0;
      trial    = '0;
      pos      = 0;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        pos   = SQ_ROOT_W - 1 - (g * SQRT_STEPS + j);
        work  = {rem_out, rad_in[2*pos +: 2]};
        trial = {2'b00, root_out, 2'b01};
        if (work >= trial) begin
          rem_out  = REM_W'(work - trial);
          root_out = {root_out[SQ_ROOT_W-2:0], 1'b1};
        end else begin
          rem_out  = REM_W'(work);
          root_out = {root_out[SQ_ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[g]  <= rad_in;
        rem_q[g]  <= rem_out;
        root_q[g] <= root_out;
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule

>>> sv/idp_exp.sv
// pipelined exp(-t): horner series of t/16 in q.31, then four squarings
// depends on idp_pkg
module idp_exp (
  input  logic                    clk,
  input  logic                    en,
  input  idp_pkg::exp_arg_t       arg,
  output logic [idp_pkg::E_W-1:0] e
);
  import idp_pkg::*;

  logic [30:0] fp_q  [EXP_TERMS];
  logic [30:0] p_q   [EXP_TERMS];
  logic [30:0] fa_q  [EXP_TERMS];
  logic [31:0] acc_q [EXP_TERMS];
  logic [31:0] sq_q  [EXP_SQUARINGS];
  logic        z_q   [EXP_LAT-1];

  for (genvar n = 0; n < EXP_TERMS; n++) begin : g_term
    localparam int K = EXP_TERMS - n;
    // exact floor division by K for 31-bit dividends
    localparam logic [35:0] RECIP = 36'(((64'd1 << 35) + 64'(K) - 64'd1) / K);

    logic [30:0] f_in;
    logic [31:0] acc_in;
    logic [62:0] prod;
    logic [66:0] qp;

    if (n == 0) begin : g_first
      assign f_in   = {arg.t, 11'd0};
      assign acc_in = Q31_ONE;
    end else begin : g_next
      assign f_in   = fa_q[n-1];
      assign acc_in = acc_q[n-1];
    end

    assign prod = 63'(f_in) * 63'(acc_in);
    assign qp   = 67'(p_q[n]) * 67'(RECIP);

    always_ff @(posedge clk) begin
      if (en) begin
        p_q[n]   <= prod[61:31];
        fp_q[n]  <= f_in;
        acc_q[n] <= Q31_ONE - {1'b0, qp[65:35]};
        fa_q[n]  <= fp_q[n];
      end
    end
  end

  for (genvar i = 0; i < EXP_SQUARINGS; i++) begin : g_square
    logic [31:0] sq_in;
    logic [63:0] sqp;
    if (i == 0) begin : g_first
      assign sq_in = acc_q[EXP_TERMS-1];
    end else begin : g_next
      assign sq_in = sq_q[i-1];
    end
    assign sqp = 64'(sq_in) * 64'(sq_in) + 64'(Q31_ONE >> 1);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_q[i] <= sqp[62:31];
      end
    end
  end

  logic [32:0] e_rnd;
  assign e_rnd = 33'(sq_q[EXP_SQUARINGS-1]) + 33'd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      z_q[0] <= arg.zero;
      for (int k = 1; k < EXP_LAT - 1; k++) begin
        z_q[k] <= z_q[k-1];
      end
      e <= z_q[EXP_LAT-2] ? '0 : e_rnd[E_W+14:15];
    end
  end

endmodule

>>> sv/inclined_disk_profile_pixel_core.sv
// inclined disk profile pixel core: rotation, radius, exp profile, gain and add
// depends on idp_pkg, idp_isqrt, idp_exp and assert_macros.svh
//
// usage:
//  - pixels enter on the s_ channel, one beat per pixel, results leave on the
//    m_ channel in the same order, one beat per pixel
//  - registers are written through cfg_we / cfg_index / cfg_data while no
//    pixel is in flight; a write lands on the next clock edge
//  - throughput is one pixel per cycle while s_tready is high; a pixel accepted
//    passes the input stage, 45 further pipeline stages and the output
//    register before it shows on m_tvalid; the depth is set by the 8-stage
//    square root and the 29-stage exp unit
//  - the whole pipeline moves on one enable; when the receiver stalls, the
//    output register holds its beat and one more beat lands in a skid
//    register, then s_tready drops until the skid drains
//  - reset (rst, synchronous) empties the pipeline and loads the register
//    defaults: amplitude 1.0, inv_scale 1.0, sin 0, cos 1.0, inv_cos_inc 1.0,
//    gain 1.0, exponential mode
`include "assert_macros.svh"

module inclined_disk_profile_pixel_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // x_offset [31:0], y_offset [63:32], old_value [95:64]
  input  logic [95:0]                     s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // new_value [31:0]
  output logic [31:0]                     m_tdata,
  // saturated [0]
  output logic [0:0]                      m_tuser,
  input  logic                            cfg_we,
  input  logic [idp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [idp_pkg::DATA_W-1:0]      cfg_data
);
  import idp_pkg::*;

  localparam int ST_S   = 6;
  localparam int ST_SQ  = ST_S + SQRT_STAGES;
  localparam int ST_T   = ST_SQ + 1;
  localparam int ST_E   = ST_T + EXP_LAT;
  localparam int ST_M   = ST_E + 1;
  localparam int PIPE_D = ST_M + 1;

  localparam logic signed [48:0] SUM_MAX = 49'sd2147483647;
  localparam logic signed [48:0] SUM_MIN = -49'sd2147483648;

  // registers
  logic [31:0]        amplitude;
  logic [23:0]        inv_scale;
  logic signed [17:0] sin_pa;
  logic signed [17:0] cos_pa;
  logic [23:0]        inv_cos_inc;
  logic [31:0]        gain;
  logic               profile_mode;
  logic [32:0]        ck;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude    <= 32'd65536;
      inv_scale    <= 24'd65536;
      sin_pa       <= '0;
      cos_pa       <= 18'sd65536;
      inv_cos_inc  <= 24'd65536;
      gain         <= 32'd65536;
      profile_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AMPLITUDE:    amplitude    <= cfg_data;
        REG_INV_SCALE:    inv_scale    <= cfg_data[RECIP_W-1:0];
        REG_SIN_PA:       sin_pa       <= $signed(cfg_data[TRIG_W-1:0]);
        REG_COS_PA:       cos_pa       <= $signed(cfg_data[TRIG_W-1:0]);
        REG_INV_COS_INC:  inv_cos_inc  <= cfg_data[RECIP_W-1:0];
        REG_GAIN:         gain         <= cfg_data;
        REG_PROFILE_MODE: profile_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // minor-axis factor, follows the registers in the cycle after they change
  logic [47:0] ck_prod;
  logic [48:0] ck_rnd;
  assign ck_prod = 48'(inv_cos_inc) * 48'(inv_scale);
  assign ck_rnd  = 49'(ck_prod) + 49'd32768;
  always_ff @(posedge clk) begin
    ck <= ck_rnd[48:16];
  end

  // flow control
  logic              advance;
  logic [PIPE_D:1]   vld;
  logic [31:0]       old_d [1:PIPE_D];
  logic              out_v;
  logic              skid_v;
  logic [31:0]       out_value;
  logic              out_sat;
  logic [31:0]       skid_value;
  logic              skid_sat;

  assign advance  = !skid_v;
  assign s_tready = advance;

  // stage registers
  logic signed [49:0] xs, xc, ys, yc;
  logic [33:0]        ax, ay;
  logic [57:0]        pu;
  logic [50:0]        pvl;
  logic [49:0]        pvh;
  logic [23:0]        u, v;
  logic [46:0]        uu, vv;
  logic [47:0]        s_reg;
  exp_arg_t           ga_d [0:SQRT_STAGES];
  exp_arg_t           targ;
  logic [SQ_ROOT_W-1:0] root;
  logic [E_W-1:0]     e;
  logic [48:0]        pm_p;
  logic [63:0]        gm_p;
  logic               neg_go;
  logic [31:0]        res_value;
  logic               res_sat;

  logic signed [31:0] x_in, y_in;
  assign x_in = $signed(s_tdata[31:0]);
  assign y_in = $signed(s_tdata[63:32]);

  // stage 2: rotation sums and rounded magnitudes
  logic signed [50:0] xr, yr;
  logic [50:0]        mx, my, rx, ry;
  assign xr = -51'(xs) - 51'(yc);
  assign yr = 51'(xc) - 51'(ys);
  assign mx = xr[50] ? 51'(-xr) : 51'(xr);
  assign my = yr[50] ? 51'(-yr) : 51'(yr);
  assign rx = mx + 51'd32768;
  assign ry = my + 51'd32768;

  // stage 4: rounding and clamping of the scaled terms
  logic [58:0] u_rnd;
  logic [67:0] v_rnd;
  assign u_rnd = (59'(pu) + 59'd32768) >> 16;
  assign v_rnd = (68'(pvl) + (68'(pvh) << 17) + 68'd32768) >> 16;

  // stage 6: radius squared and the gaussian argument
  logic [47:0] s_sum;
  logic [48:0] tg_full;
  assign s_sum   = 48'(uu) + 48'(vv);
  assign tg_full = (49'(s_sum) + 49'd65536) >> 17;

  idp_isqrt u_isqrt (
    .clk  (clk),
    .en   (advance),
    .rad  (s_reg),
    .root (root)
  );

  idp_exp u_exp (
    .clk (clk),
    .en  (advance),
    .arg (targ),
    .e   (e)
  );

  // gain and profile products
  logic [31:0] amp_mag, gain_mag, old_mag;
  assign amp_mag  = amplitude[31] ? 32'(-amplitude) : amplitude;
  assign gain_mag = gain[31] ? 32'(-gain) : gain;
  assign old_mag  = old_d[ST_E][31] ? 32'(-old_d[ST_E]) : old_d[ST_E];

  // final sum and clipping
  logic [49:0]        pm_rnd;
  logic [64:0]        gm_rnd;
  logic signed [48:0] prof, scaled, sum;
  assign pm_rnd = (50'(pm_p) + 50'd32768) >> 16;
  assign gm_rnd = (65'(gm_p) + 65'd32768) >> 16;
  assign prof   = amplitude[31] ? -$signed(49'(pm_rnd[32:0])) : $signed(49'(pm_rnd[32:0]));
  assign scaled = neg_go ? -$signed(49'(gm_rnd[46:0])) : $signed(49'(gm_rnd[46:0]));
  assign sum    = scaled + prof;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[PIPE_D-1:1], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      old_d[1] <= s_tdata[95:64];
      for (int k = 2; k <= PIPE_D; k++) begin
        old_d[k] <= old_d[k-1];
      end
      xs <= 50'(x_in) * 50'(sin_pa);
      xc <= 50'(x_in) * 50'(cos_pa);
      ys <= 50'(y_in) * 50'(sin_pa);
      yc <= 50'(y_in) * 50'(cos_pa);
      ax <= rx[49:16];
      ay <= ry[49:16];
      pu  <= 58'(ax) * 58'(inv_scale);
      pvl <= 51'(ay) * 51'(ck[16:0]);
      pvh <= 50'(ay) * 50'(ck[32:17]);
      u <= (u_rnd > 59'(RADIUS_CAP)) ? RADIUS_CAP : u_rnd[23:0];
      v <= (v_rnd > 68'(RADIUS_CAP)) ? RADIUS_CAP : v_rnd[23:0];
      uu <= 47'(u) * 47'(u);
      vv <= 47'(v) * 47'(v);
      s_reg         <= s_sum;
      ga_d[0].zero  <= tg_full >= 49'(EXP_ZERO_T);
      ga_d[0].t     <= tg_full[EXP_T_W-1:0];
      for (int k = 1; k <= SQRT_STAGES; k++) begin
        ga_d[k] <= ga_d[k-1];
      end
      if (profile_mode) begin
        targ <= ga_d[SQRT_STAGES];
      end else begin
        targ.zero <= root >= SQ_ROOT_W'(EXP_ZERO_T);
        targ.t    <= root[EXP_T_W-1:0];
      end
      pm_p   <= 49'(amp_mag) * 49'(e);
      gm_p   <= 64'(gain_mag) * 64'(old_mag);
      neg_go <= gain[31] ^ old_d[ST_E][31];
      if (amplitude == '0) begin
        res_value <= old_d[ST_M];
        res_sat   <= 1'b0;
      end else if (sum > SUM_MAX) begin
        res_value <= 32'h7fff_ffff;
        res_sat   <= 1'b1;
      end else if (sum < SUM_MIN) begin
        res_value <= 32'h8000_0000;
        res_sat   <= 1'b1;
      end else begin
        res_value <= sum[31:0];
        res_sat   <= 1'b0;
      end
    end
  end

  // output register with one skid entry
  logic pop, push;
  assign pop  = out_v && m_tready;
  assign push = advance && vld[PIPE_D];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) begin
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (out_v && !pop) begin
        skid_v <= 1'b1;
      end else begin
        out_v <= 1'b1;
      end
    end else if (pop) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pop) begin
        out_value <= skid_value;
        out_sat   <= skid_sat;
      end
    end else if (push) begin
      if (out_v && !pop) begin
        skid_value <= res_value;
        skid_sat   <= res_sat;
      end else begin
        out_value <= res_value;
        out_sat   <= res_sat;
      end
    end
  end

  assign m_tvalid   = out_v;
  assign m_tdata    = out_value;
  assign m_tuser[0] = out_sat;

  `ASSERT_IMPL(a_skid_needs_main, clk, rst, skid_v, out_v)
  `ASSERT_CLK(a_skid_holds, clk, rst, (skid_v && !m_tready) |=> skid_v)
  `ASSERT_IMPL(a_sat_bound, clk, rst, m_tvalid && m_tuser[0], m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000)

endmodule
